@@ hw/rtl/rtan_pkg.sv @@
// shared types, constants and codes of the rate averaged time normalizer
package rtan_pkg;

  localparam int TIME_W = 64;
  localparam int RATE_W = 48;
  localparam int FRAC_W = 32;
  localparam int ENT_W = 6;
  localparam int WS_W = 5;
  localparam int DIV_DVD_W = 96;
  localparam int DIV_CNT_W = 7;

  localparam int DEF_ENT_COUNT = 64;
  localparam int DEF_WINDOW_MAX = 16;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WIDE = 7'd96;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_NARROW = 7'd64;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_START_WALL  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [ENT_W-1:0]  ent_id;
    logic [TIME_W-1:0] sim_time;
    logic [TIME_W-1:0] wall_time;
  } in_t;

  typedef struct packed {
    logic [TIME_W-1:0] norm_time;
    logic              order_error;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ENT,
    ST_RD_NEW,
    ST_RD_HEAD,
    ST_DIV_RATE,
    ST_MEAN_MUL,
    ST_MEAN_SUB,
    ST_DIV_MEAN,
    ST_PROD,
    ST_UPDATE,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic start;
    logic narrow;
  } div_ctl_t;

endpackage

@@ hw/rtl/rtan_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module rtan_div import rtan_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_ctl_t             ctl,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [TIME_W-1:0]    divisor,
  output logic                 done,
  output logic [TIME_W-1:0]    quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TIME_W-1:0]    rem_r;
  logic [DIV_DVD_W-1:0] dvd_r;
  logic [TIME_W-1:0]    den_r;
  logic [TIME_W-1:0]    q_r;

  logic [TIME_W:0] shifted;
  logic [TIME_W:0] diff;
  logic            ge;

  always_comb begin
    shifted = {rem_r, dvd_r[DIV_DVD_W-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !ctl.start && busy_r && (cnt_r == DIV_CNT_W'(1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.narrow ? DIV_STEPS_NARROW : DIV_STEPS_WIDE;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      den_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      dvd_r <= {dvd_r[DIV_DVD_W-2:0], 1'b0};
      q_r   <= {q_r[TIME_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ hw/rtl/rate_averaged_time_normalizer_core.sv @@
// top level of the rate averaged time normalizer
// Each request carries an entity id, its simulated time and the wall time; the block returns
// the integer part of a global normalized time, which grows by the mean progress rate of the
// active entities times the wall time since the previous good request. Per-entity history
// pairs and window state live in two one-read one-write synchronous memories; one request is
// in work at a time. A good request passes the accepting state, three memory reads, the 96-step
// rate division, the mean numerator in two states, the 64-step mean division in the same shared
// radix-2 divider, four 32x32 partial products for the time advance, one write-back and the
// loading of the output register. A saturated rate skips the rate division. A rejected request
// (entity out of range or simulated time not increasing) skips the arithmetic and goes on to
// the output register. The next request is taken while a result still waits at the output
// register. After reset and after every start_wall_time write a clearing pass over all
// ENT_COUNT entries seeds the memories; configuration writes are taken at any time.
module rate_averaged_time_normalizer_core import rtan_pkg::*; #(
  parameter int ENT_COUNT  = DEF_ENT_COUNT,
  parameter int WINDOW_MAX = DEF_WINDOW_MAX
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [TIME_W-1:0] cfg_wdata
);

  // widths follow from the entity count and window depth
  localparam int EW   = (ENT_COUNT > 1) ? $clog2(ENT_COUNT) : 1;
  localparam int SLW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int AW   = $clog2(ENT_COUNT + 1);
  localparam int HD   = ENT_COUNT * WINDOW_MAX;
  localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;
  localparam int SUMW = SLW + 2;
  localparam int ACCW = 112;

  typedef struct packed {
    logic [SLW-1:0]    head;
    logic [CW-1:0]     count;
    logic [RATE_W-1:0] rate;
  } ent_t;

  typedef struct packed {
    logic [TIME_W-1:0] sim;
    logic [TIME_W-1:0] wall;
  } hist_t;

  // circular window index
  function automatic logic [SLW-1:0] wrap(input logic [SUMW-1:0] x);
    logic [SUMW-1:0] w;
    w = SUMW'(WINDOW_MAX);
    if (x >= w) return SLW'(x - w);
    return SLW'(x);
  endfunction

  function automatic logic [HAW-1:0] haddr(input logic [EW-1:0] e, input logic [SLW-1:0] s);
    return HAW'(HAW'(e) * HAW'(WINDOW_MAX) + HAW'(s));
  endfunction

  // memories
  ent_t  ent_mem [ENT_COUNT];
  hist_t hist_mem [HD];

  logic           ent_we;
  logic [EW-1:0]  ent_waddr;
  logic [EW-1:0]  ent_raddr;
  ent_t           ent_wdata;
  ent_t           ent_q;
  logic           hist_we;
  logic [HAW-1:0] hist_waddr;
  logic [HAW-1:0] hist_raddr;
  hist_t          hist_wdata;
  hist_t          hist_q;

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q <= hist_mem[hist_raddr];
  end

  // control and datapath state
  state_t              state_r, state_nxt;
  logic [EW-1:0]       clr_r;
  logic [WS_W-1:0]     ws_r;
  logic [TIME_W-1:0]   start_r;
  in_t                 in_r;
  logic [EW-1:0]       eidx_r;
  logic [SLW-1:0]      head_r;
  logic [CW-1:0]       count_r;
  logic [RATE_W-1:0]   old_r;
  logic [RATE_W-1:0]   rate_r;
  logic [RATE_W-1:0]   mean_r;
  logic [AW-1:0]       act_r;
  logic [AW-1:0]       curr_r;
  logic [TIME_W-1:0]   prod_r;
  logic [TIME_W-1:0]   dwg_r;
  logic [ACCW-1:0]     acc_r;
  logic [1:0]          pp_cnt_r;
  logic [TIME_W-1:0]   int_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [TIME_W-1:0]   last_wall_r;
  out_t                res_r;
  logic                out_valid_r;
  out_t                out_data_r;

  logic restart;
  logic in_acc;
  logic ent_ok;
  logic order_bad;
  logic [SLW-1:0] newest_rd;
  logic [TIME_W-1:0] dsim;
  logic [TIME_W-1:0] dwall;
  logic rate_sat;
  logic act_inc;
  logic [AW-1:0] curr_c;
  logic [TIME_W-1:0] msum;
  logic [TIME_W-1:0] mnum;
  logic [TIME_W-1:0] div_q;
  logic div_done;
  div_ctl_t div_ctl;
  logic [DIV_DVD_W-1:0] div_dvd;
  logic [TIME_W-1:0] div_den;
  logic [31:0] pp_a;
  logic [31:0] pp_b;
  logic [TIME_W-1:0] pp;
  logic [ACCW-1:0] pp_sh;
  logic [TIME_W+FRAC_W:0] nsum;
  logic nov;
  logic [31:0] win;
  logic drop;
  logic [SLW-1:0] head_n;
  logic [CW-1:0] count_n;
  logic [SLW-1:0] slot_n;
  logic out_load;

  assign restart = cfg_we && (cfg_index == CFG_START_WALL);
  assign in_acc  = in_valid && in_ready;
  assign ent_ok  = 32'(in_data.ent_id) < ENT_COUNT;

  // read side: newest slot from the entity entry, then the oldest pair
  assign newest_rd = wrap(SUMW'(ent_q.head) + SUMW'(ent_q.count) - SUMW'(1));
  assign order_bad = in_r.sim_time <= hist_q.sim;
  assign dsim      = in_r.sim_time - hist_q.sim;
  assign dwall     = in_r.wall_time - hist_q.wall;
  // zero wall difference or a quotient beyond Q16.32 saturates
  assign rate_sat  = (dwall == '0) || ({16'b0, dsim[TIME_W-1:16]} >= dwall);

  // activation: a zero stored rate counts as a new entity
  assign act_inc = (old_r == '0) && (act_r < AW'(ENT_COUNT));
  assign curr_c  = act_inc ? act_r + 1'b1 : act_r;

  // mean numerator, clamped at zero
  assign msum = prod_r + TIME_W'(rate_r);
  assign mnum = (msum >= TIME_W'(old_r)) ? msum - TIME_W'(old_r) : '0;

  // partial products of mean times elapsed wall time
  assign pp_a = pp_cnt_r[1] ? {16'b0, mean_r[RATE_W-1:32]} : mean_r[31:0];
  assign pp_b = pp_cnt_r[0] ? dwg_r[TIME_W-1:32] : dwg_r[31:0];
  assign pp   = pp_a * pp_b;
  always_comb begin
    case (pp_cnt_r)
      2'd0:    pp_sh = ACCW'(pp);
      2'd3:    pp_sh = ACCW'(pp) << 64;
      default: pp_sh = ACCW'(pp) << 32;
    endcase
  end

  // Q64.32 accumulate with saturation
  assign nsum = {1'b0, int_r, frac_r} + {1'b0, acc_r[TIME_W+FRAC_W-1:0]};
  assign nov  = nsum[TIME_W+FRAC_W] || (acc_r[ACCW-1:TIME_W+FRAC_W] != '0);

  // window update
  always_comb begin
    if (ws_r == '0) win = 32'd1;
    else if (32'(ws_r) > WINDOW_MAX) win = WINDOW_MAX;
    else win = 32'(ws_r);
  end
  assign drop    = 32'(count_r) >= win;
  assign head_n  = drop ? wrap(SUMW'(head_r) + SUMW'(1)) : head_r;
  assign count_n = drop ? count_r - 1'b1 : count_r;
  assign slot_n  = wrap(SUMW'(head_n) + SUMW'(count_n));

  assign out_load = (state_r == ST_OUT_WAIT) && (!out_valid_r || out_ready);

  rtan_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_r == EW'(ENT_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ent_ok ? ST_RD_ENT : ST_OUT_WAIT;
      ST_RD_ENT:   state_nxt = ST_RD_NEW;
      ST_RD_NEW:   state_nxt = order_bad ? ST_OUT_WAIT : ST_RD_HEAD;
      ST_RD_HEAD:  state_nxt = rate_sat ? ST_MEAN_MUL : ST_DIV_RATE;
      ST_DIV_RATE: if (div_done) state_nxt = ST_MEAN_MUL;
      ST_MEAN_MUL: state_nxt = ST_MEAN_SUB;
      ST_MEAN_SUB: state_nxt = (curr_r == '0) ? ST_PROD : ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_done) state_nxt = ST_PROD;
      ST_PROD:     if (pp_cnt_r == 2'd3) state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
    if (restart) state_nxt = ST_CLEAR;
  end

  // outputs of the state machine: handshake, divider and memory ports
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    div_ctl     = '0;
    div_dvd     = {dsim, 32'b0};
    div_den     = dwall;
    ent_we      = 1'b0;
    ent_waddr   = eidx_r;
    ent_wdata   = '{head: head_n, count: count_n + 1'b1, rate: rate_r};
    ent_raddr   = (state_r == ST_IDLE) ? EW'(in_data.ent_id) : eidx_r;
    hist_we     = 1'b0;
    hist_waddr  = haddr(eidx_r, slot_n);
    hist_wdata  = '{sim: in_r.sim_time, wall: in_r.wall_time};
    hist_raddr  = (state_r == ST_RD_ENT) ? haddr(eidx_r, newest_rd) : haddr(eidx_r, head_r);
    unique case (state_r)
      ST_CLEAR: begin
        ent_we     = 1'b1;
        ent_waddr  = clr_r;
        ent_wdata  = '{head: '0, count: CW'(1), rate: '0};
        hist_we    = 1'b1;
        hist_waddr = haddr(clr_r, '0);
        hist_wdata = '{sim: '0, wall: start_r};
      end
      ST_RD_HEAD: div_ctl.start = !rate_sat;
      ST_MEAN_SUB: begin
        div_ctl.start  = (curr_r != '0);
        div_ctl.narrow = 1'b1;
        div_dvd        = {mnum, 32'b0};
        div_den        = TIME_W'(curr_r);
      end
      ST_UPDATE: begin
        ent_we  = 1'b1;
        hist_we = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ws_r        <= WS_W'(1);
      start_r     <= '0;
      mean_r      <= '0;
      act_r       <= '0;
      int_r       <= '0;
      frac_r      <= '0;
      last_wall_r <= '0;
      out_valid_r <= 1'b0;
      pp_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && (cfg_index == CFG_WINDOW_SIZE)) ws_r <= cfg_wdata[WS_W-1:0];
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // a new start time restarts everything but the window size and a waiting result
      if (restart) begin
        start_r     <= cfg_wdata;
        clr_r       <= '0;
        mean_r      <= '0;
        act_r       <= '0;
        int_r       <= '0;
        frac_r      <= '0;
        last_wall_r <= cfg_wdata;
      end else begin
        if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
        if (state_r == ST_MEAN_MUL) begin
          act_r    <= curr_c;
          pp_cnt_r <= '0;
        end
        if (state_r == ST_MEAN_SUB && curr_r == '0) mean_r <= '0;
        if (state_r == ST_DIV_MEAN && div_done) begin
          mean_r <= (div_q > TIME_W'(RATE_MAX)) ? RATE_MAX : div_q[RATE_W-1:0];
        end
        if (state_r == ST_PROD) pp_cnt_r <= pp_cnt_r + 1'b1;
        if (state_r == ST_UPDATE) begin
          int_r       <= nov ? '1 : nsum[TIME_W+FRAC_W-1:FRAC_W];
          frac_r      <= nov ? '1 : nsum[FRAC_W-1:0];
          last_wall_r <= in_r.wall_time;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r   <= in_data;
      eidx_r <= EW'(in_data.ent_id);
      res_r  <= '{norm_time: int_r, order_error: 1'b1};
    end
    if (state_r == ST_RD_ENT) begin
      head_r  <= ent_q.head;
      count_r <= ent_q.count;
      old_r   <= ent_q.rate;
    end
    if (state_r == ST_RD_HEAD && rate_sat) rate_r <= RATE_MAX;
    if (state_r == ST_DIV_RATE && div_done) rate_r <= div_q[RATE_W-1:0];
    if (state_r == ST_MEAN_MUL) begin
      curr_r <= curr_c;
      prod_r <= TIME_W'(mean_r) * TIME_W'(act_r);
      dwg_r  <= in_r.wall_time - last_wall_r;
      acc_r  <= '0;
    end
    if (state_r == ST_PROD) acc_r <= acc_r + pp_sh;
    if (state_r == ST_UPDATE) begin
      res_r <= '{norm_time: nov ? '1 : nsum[TIME_W+FRAC_W-1:FRAC_W],
                 order_error: 1'b0};
    end
    if (out_load) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/rtan_chk.sv @@
// port-level checker of the rate averaged time normalizer and its bind
module rtan_chk import rtan_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input in_t      in_data,
  input logic     out_valid,
  input logic     out_ready,
  input out_t     out_data,
  input logic     cfg_we,
  input cfg_idx_t cfg_index
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // a new start time begins a clearing pass
  a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == CFG_START_WALL |=> !in_ready)
    else $error("request taken during clearing pass");

endmodule

bind rate_averaged_time_normalizer_core rtan_chk u_rtan_chk (.*);

@@ verif/tb_top.sv @@
// self-checking testbench of the rate averaged time normalizer core
`timescale 1ns / 1ps

module tb_top;
  import rtan_pkg::*;

  localparam int N_ENT = DEF_ENT_COUNT;
  localparam int W_MAX = DEF_WINDOW_MAX;
  // long enough to cover any work still in flight
  localparam int SETTLE_CYCLES = 300;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [TIME_W-1:0] cfg_wdata;

  rate_averaged_time_normalizer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow state of the normalizer
  logic [TIME_W-1:0] sim_hist [N_ENT][W_MAX];
  logic [TIME_W-1:0] wall_hist [N_ENT][W_MAX];
  int                hist_head [N_ENT];
  int                hist_cnt [N_ENT];
  logic [RATE_W-1:0] ent_rate [N_ENT];
  logic [RATE_W-1:0] mean_rate;
  int                active_cnt;
  logic [TIME_W-1:0] norm_int;
  logic [FRAC_W-1:0] norm_frac;
  logic [TIME_W-1:0] last_wall;
  int                win_size;
  logic [TIME_W-1:0] start_wall;

  out_t exp_norm_q[$];
  int   n_accepted;
  int   n_mismatch;
  bit   calm;

  // back to reset values, seeded with the start wall time
  function automatic void clear_state();
    for (int e = 0; e < N_ENT; e++) begin
      for (int i = 0; i < W_MAX; i++) begin
        sim_hist[e][i] = '0;
        wall_hist[e][i] = '0;
      end
      wall_hist[e][0] = start_wall;
      hist_head[e] = 0;
      hist_cnt[e] = 1;
      ent_rate[e] = '0;
    end
    mean_rate = '0;
    active_cnt = 0;
    norm_int = '0;
    norm_frac = '0;
    last_wall = start_wall;
  endfunction

  function automatic logic [TIME_W-1:0] newest_sim(int e);
    return sim_hist[e][(hist_head[e] + hist_cnt[e] - 1) % W_MAX];
  endfunction

  // advance the shadow state by one request and return its result
  function automatic out_t normalize_step(in_t it);
    int                e;
    int                hd;
    int                cnt;
    int                prev;
    int                win;
    logic [TIME_W-1:0] dsim;
    logic [TIME_W-1:0] dwall;
    logic [95:0]       quot;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] old_rate;
    logic [63:0]       num;
    logic [111:0]      prod;
    logic [96:0]       acc;
    bit                ovf;
    out_t              res;
    e = it.ent_id;
    res.order_error = 1'b1;
    res.norm_time = norm_int;
    if (e >= N_ENT) return res;
    if (it.sim_time <= newest_sim(e)) return res;
    hd = hist_head[e];
    cnt = hist_cnt[e];
    dsim = it.sim_time - sim_hist[e][hd];
    dwall = it.wall_time - wall_hist[e][hd];
    // rate in Q16.32, saturating on zero or too small wall difference
    if (dwall == 0 || (dsim >> 16) >= dwall) begin
      rate = RATE_MAX;
    end else begin
      quot = {dsim, 32'b0} / {32'b0, dwall};
      rate = quot[RATE_W-1:0];
    end
    // incremental mean over active entities
    prev = active_cnt;
    old_rate = ent_rate[e];
    if (old_rate == 0 && active_cnt < N_ENT) active_cnt++;
    num = {16'b0, mean_rate} * 64'(prev) + {16'b0, rate};
    num = (num >= {16'b0, old_rate}) ? num - {16'b0, old_rate} : '0;
    if (active_cnt == 0) begin
      mean_rate = '0;
    end else begin
      num = num / 64'(active_cnt);
      mean_rate = (num > {16'b0, RATE_MAX}) ? RATE_MAX : num[RATE_W-1:0];
    end
    ent_rate[e] = rate;
    // Q64.32 time advance, saturating to all ones
    prod = {64'b0, mean_rate} * {48'b0, it.wall_time - last_wall};
    ovf = |prod[111:96];
    acc = {1'b0, norm_int, norm_frac} + {1'b0, prod[95:0]};
    ovf = ovf | acc[96];
    if (ovf) begin
      norm_int = '1;
      norm_frac = '1;
    end else begin
      norm_int = acc[95:32];
      norm_frac = acc[31:0];
    end
    last_wall = it.wall_time;
    // window slide, then append the new pair
    win = (win_size == 0) ? 1 : (win_size > W_MAX) ? W_MAX : win_size;
    if (cnt >= win) begin
      hd = (hd + 1) % W_MAX;
      cnt--;
    end
    sim_hist[e][(hd + cnt) % W_MAX] = it.sim_time;
    wall_hist[e][(hd + cnt) % W_MAX] = it.wall_time;
    hist_head[e] = hd;
    hist_cnt[e] = cnt + 1;
    res.order_error = 1'b0;
    res.norm_time = norm_int;
    return res;
  endfunction

  task automatic report(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
    n_mismatch++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

  // monitor: compare results first, then predict the newly accepted request
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (exp_norm_q.size() == 0) begin
          report("unexpected result", '0, out_data.norm_time);
        end else begin
          want = exp_norm_q.pop_front();
          if (out_data.norm_time !== want.norm_time)
            report("norm_time", want.norm_time, out_data.norm_time);
          if (out_data.order_error !== want.order_error)
            report("order_error", 64'(want.order_error), 64'(out_data.order_error));
        end
      end
      if (in_valid && in_ready) begin
        exp_norm_q.push_back(normalize_step(in_data));
        n_accepted++;
      end
    end
  end

  // result side stalls in bursts, none in the calm tail
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 15) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // present one request and hold it until accepted
  task automatic send_request(in_t it);
    int seen;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    seen = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  // wait for the block to drain
  task automatic drain();
    in_valid <= 1'b0;
    while (exp_norm_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(cfg_idx_t idx, logic [TIME_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_WINDOW_SIZE) begin
      win_size = int'(val[WS_W-1:0]);
    end else begin
      start_wall = val;
      clear_state();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    in_t               it;
    logic [TIME_W-1:0] wall_now;
    int                pool;
    int                e;
    int                n_items;
    int                wsz [5];
    bit                restart [5];
    logic [TIME_W-1:0] swall [5];
    out_t              got_pred;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WINDOW_SIZE;
    cfg_wdata = '0;
    n_accepted = 0;
    n_mismatch = 0;
    calm = 1'b0;
    win_size = 1;
    start_wall = '0;
    clear_state();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, state right after reset
    // simulated time zero is not past the seeded history
    dir_rows.push_back('{'{6'd0, 64'd0, 64'd5}, 1'b1, '{64'd0, 1'b1}});
    // zero wall difference saturates the rate; no wall time has passed
    dir_rows.push_back('{'{6'd0, 64'd1000, 64'd0}, 1'b1, '{64'd0, 1'b0}});
    dir_rows.push_back('{'{6'd0, 64'd2000, 64'd1000}, 1'b0, '{64'd0, 1'b0}});
    dir_rows.push_back('{'{6'd63, '1, '1}, 1'b0, '{64'd0, 1'b0}});
    dir_rows.push_back('{'{6'd63, '1, 64'd1}, 1'b0, '{64'd0, 1'b0}});
    dir_rows.push_back('{'{6'd1, 64'd1, '1}, 1'b0, '{64'd0, 1'b0}});
    dir_rows.push_back('{'{6'd2, '1, 64'd2}, 1'b0, '{64'd0, 1'b0}});
    dir_rows.push_back('{'{6'd0, 64'd1500, 64'd3}, 1'b0, '{64'd0, 1'b0}});
    dir_rows.push_back('{'{6'd3, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
                         1'b0, '{64'd0, 1'b0}});
    dir_rows.push_back('{'{6'd42, 64'd1, 64'd0}, 1'b0, '{64'd0, 1'b0}});
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req);
      // typed rows are checked against the prediction they must agree with
      if (dir_rows[i].typed) begin
        got_pred = exp_norm_q[$];
        if (got_pred !== dir_rows[i].want)
          report("directed row", 64'(dir_rows[i].want), 64'(got_pred));
      end
    end

    // phases: window size, optional restart with a new start wall time
    wsz = '{1, 16, 0, 31, 3};
    restart = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    swall = '{64'd0, rand64(), '1, 64'd0, 64'd0};
    n_items = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_WINDOW_SIZE, 64'(wsz[ph]));
      if (restart[ph]) write_reg(CFG_START_WALL, swall[ph]);
      wall_now = start_wall;
      pool = (ph % 2 == 0) ? 4 : N_ENT;
      for (int k = 0; k < 400; k++) begin
        if (n_items >= 1800) calm = 1'b1;
        // sender waits for everything to come back once
        if (ph == 2 && k == 200) begin
          in_valid <= 1'b0;
          while (exp_norm_q.size() != 0) @(negedge clk);
        end
        e = $urandom_range(0, pool - 1);
        case ($urandom_range(0, 9))
          0: begin
            // noise over every bit
            it.ent_id = ENT_W'($urandom);
            it.sim_time = rand64();
            it.wall_time = rand64();
          end
          1: begin
            // time not increasing
            it.ent_id = ENT_W'(e);
            it.sim_time = newest_sim(e) - $urandom_range(0, 3);
            it.wall_time = wall_now;
          end
          2: begin
            // big jumps push rates and the normalized time to saturation
            wall_now = wall_now + $urandom_range(0, 3);
            it.ent_id = ENT_W'(e);
            it.sim_time = newest_sim(e) + {$urandom_range(1, 255), $urandom};
            it.wall_time = wall_now;
          end
          default: begin
            wall_now = wall_now + $urandom_range(0, 500);
            it.ent_id = ENT_W'(e);
            it.sim_time = newest_sim(e) + $urandom_range(1, 2000);
            it.wall_time = wall_now;
          end
        endcase
        send_request(it);
        n_items++;
      end
    end

    in_valid <= 1'b0;
    while (exp_norm_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (n_mismatch == 0 && exp_norm_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rtan_pkg.sv
hw/rtl/rtan_div.sv
hw/rtl/rate_averaged_time_normalizer_core.sv
hw/rtl/rtan_chk.sv
verif/tb_top.sv
